/* hdl/line_follow_pid_steering_core_defines.svh */
// Assertion macros for the steering core; only the sequencer uses them.
`ifndef LINE_FOLLOW_PID_STEERING_CORE_DEFINES_SVH
`define LINE_FOLLOW_PID_STEERING_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define LFPS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define LFPS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/lfps_pkg.sv */
// Types, constants, arithmetic helpers and microcode table of the steering core.
`default_nettype none

package lfps_pkg;

   // Filter coefficient, unsigned Q0.16 (65536 is 1.0).
   localparam int unsigned FILTER_COEF = 6554;
   localparam logic signed [32:0] COEF_OPND = 33'(FILTER_COEF);

   // Port widths.
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 64;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;

   // Datapath widths: operand, raw product, rounded product, turn sum.
   localparam int OPND_W = 33;
   localparam int PROD_W = 66;
   localparam int RND_W  = 50;
   localparam int WIDE_W = 53;

   localparam logic signed [31:0] I32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] I32_MIN = 32'sh8000_0000;

   // Command codes carried in the request tuser.
   localparam logic [1:0] CMD_P     = 2'd0;
   localparam logic [1:0] CMD_PID   = 2'd1;
   localparam logic [1:0] CMD_EVENT = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_SPEED     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_OFFSET_P  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_HEADING_P = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_SLOWDOWN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_OFFSET_I  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_HEADING_I = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_OFFSET_D  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_HEADING_D = 3'd7;

   // Program counter and program layout.
   localparam int PC_W = 5;
   localparam logic [PC_W-1:0] PC_PID_ENTRY = 5'd8;
   localparam logic [PC_W-1:0] PC_LAST      = 5'd16;

   // Multiplier operand A select.
   typedef enum logic [3:0] {
      A_DIFF_O, A_DIFF_H, A_ABS_EO, A_ABS_EH, A_ERR_O,
      A_ERR_H, A_DLT_O, A_DLT_H, A_ACC_O, A_ACC_H
   } a_sel_type;

   // Multiplier operand B select.
   typedef enum logic [2:0] {
      B_COEF, B_SLOW, B_KP_O, B_KP_H, B_KD_O, B_KD_H, B_KI_O, B_KI_H
   } b_sel_type;

   // Datapath operation that consumes the registered product.
   typedef enum logic [2:0] {
      OP_NOP, OP_FILT_O, OP_FILT_H, OP_DIFF, OP_SLOW, OP_TFIRST, OP_TSUB, OP_OUT
   } op_type;

   // One microcode word.
   typedef struct packed {
      a_sel_type        mul_a;
      b_sel_type        mul_b;
      op_type           op;
      logic             acc_upd;
      logic             jmp_pid;
      logic [PC_W-1:0]  target;
      logic             last;
   } ucode_type;

   // Control from the sequencer to the datapath.
   typedef struct packed {
      a_sel_type  mul_a;
      b_sel_type  mul_b;
      op_type     op;
      logic       acc_upd;
      logic       load;
      logic       evt;
   } lfps_ctl_type;

   // Configuration registers.
   typedef struct packed {
      logic        [30:0] base_speed;
      logic signed [31:0] gain_offset_p;
      logic signed [31:0] gain_heading_p;
      logic signed [31:0] gain_slowdown;
      logic signed [31:0] gain_offset_i;
      logic signed [31:0] gain_heading_i;
      logic signed [31:0] gain_offset_d;
      logic signed [31:0] gain_heading_d;
   } lfps_cfg_type;

   // Saturates a wide signed value to the 32-bit signed range.
   function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
      if (v > 53'sd2147483647) begin
         return I32_MAX;
      end else if (v < -53'sd2147483648) begin
         return I32_MIN;
      end
      return v[31:0];
   endfunction

   // Saturating negation.
   function automatic logic signed [31:0] neg32(input logic signed [31:0] f);
      return (f == I32_MIN) ? I32_MAX : -f;
   endfunction

   // Q16.16 product reduction, round half up: floor((p + 2^15) / 2^16).
   function automatic logic signed [RND_W-1:0] rnd16(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] q;
      q = p + 66'sd32768;
      return q[PROD_W-1:16];
   endfunction

   // Microcode table. The P law runs steps 0 to 7, the PID law jumps from
   // step 2 to step 8 and runs to step 16. Each step consumes the product
   // issued by the step before it.
   function automatic ucode_type urom(input logic [PC_W-1:0] pc);
      ucode_type w;
      w.mul_a   = A_DIFF_O;
      w.mul_b   = B_COEF;
      w.op      = OP_NOP;
      w.acc_upd = 1'b0;
      w.jmp_pid = 1'b0;
      w.target  = PC_PID_ENTRY;
      w.last    = 1'b0;
      case (pc)
         5'd0: begin
            w.mul_a = A_DIFF_O; w.mul_b = B_COEF;
         end
         5'd1: begin
            w.op = OP_FILT_O; w.mul_a = A_DIFF_H; w.mul_b = B_COEF;
         end
         5'd2: begin
            w.op = OP_FILT_H; w.jmp_pid = 1'b1;
         end
         5'd3: begin
            w.mul_a = A_ABS_EO; w.mul_b = B_SLOW;
         end
         5'd4: begin
            w.op = OP_SLOW; w.mul_a = A_ERR_O; w.mul_b = B_KP_O;
         end
         5'd5: begin
            w.op = OP_TFIRST; w.mul_a = A_ERR_H; w.mul_b = B_KP_H;
         end
         5'd6: begin
            w.op = OP_TSUB;
         end
         5'd7: begin
            w.op = OP_OUT; w.last = 1'b1;
         end
         5'd8: begin
            w.op = OP_DIFF; w.mul_a = A_ABS_EH; w.mul_b = B_SLOW;
         end
         5'd9: begin
            w.op = OP_SLOW; w.acc_upd = 1'b1; w.mul_a = A_ERR_O; w.mul_b = B_KP_O;
         end
         5'd10: begin
            w.op = OP_TFIRST; w.mul_a = A_ERR_H; w.mul_b = B_KP_H;
         end
         5'd11: begin
            w.op = OP_TSUB; w.mul_a = A_DLT_O; w.mul_b = B_KD_O;
         end
         5'd12: begin
            w.op = OP_TSUB; w.mul_a = A_DLT_H; w.mul_b = B_KD_H;
         end
         5'd13: begin
            w.op = OP_TSUB; w.mul_a = A_ACC_O; w.mul_b = B_KI_O;
         end
         5'd14: begin
            w.op = OP_TSUB; w.mul_a = A_ACC_H; w.mul_b = B_KI_H;
         end
         5'd15: begin
            w.op = OP_TSUB;
         end
         5'd16: begin
            w.op = OP_OUT; w.last = 1'b1;
         end
         default: begin
            w.last = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

/* hdl/lfps_sequencer.sv */
// Microcode sequencer: request handshake, step counter and control word fetch.
`default_nettype none

`include "line_follow_pid_steering_core_defines.svh"

module lfps_sequencer
   import lfps_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [1:0]    req_tuser,
   input  wire logic          out_stall,
   output lfps_ctl_type       ctl
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } seq_state_type;

   seq_state_type    state_ff, state_in;
   logic [PC_W-1:0]  pc_ff, pc_in;
   logic             pid_ff, pid_in;
   ucode_type        word;
   logic             accept;
   logic             is_sample;
   logic             out_op_stall;
   logic             step_en;

   // Fetch the current control word.
   assign word         = urom(pc_ff);
   assign out_op_stall = (word.op == OP_OUT) && out_stall;
   assign step_en      = (state_ff == ST_RUN) && !out_op_stall;

   // A new request is taken only between programs.
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign is_sample  = (req_tuser == CMD_P) || (req_tuser == CMD_PID);

   // Step counter with the conditional jump into the PID program.
   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      pid_in   = pid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && is_sample) begin
               state_in = ST_RUN;
               pc_in    = '0;
               pid_in   = (req_tuser == CMD_PID);
            end
         end
         ST_RUN: begin
            if (step_en) begin
               if (word.last) begin
                  state_in = ST_IDLE;
               end else if (word.jmp_pid && pid_ff) begin
                  pc_in = word.target;
               end else begin
                  pc_in = pc_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
         pid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         pid_ff   <= pid_in;
      end
   end

   // Drive the datapath; operations only take effect on an active step.
   always_comb begin
      ctl.mul_a   = word.mul_a;
      ctl.mul_b   = word.mul_b;
      ctl.op      = step_en ? word.op : OP_NOP;
      ctl.acc_upd = step_en && word.acc_upd;
      ctl.load    = accept && is_sample;
      ctl.evt     = accept && (req_tuser == CMD_EVENT);
   end

   `LFPS_ASSERT_NEXT(a_sample_starts, accept && is_sample, state_ff == ST_RUN && pc_ff == '0, "sample request did not start the program")
   `LFPS_ASSERT_NEXT(a_stall_holds, state_ff == ST_RUN && out_op_stall, state_ff == ST_RUN && $stable(pc_ff), "program moved while the result register was full")
   `LFPS_ASSERT_SAME(a_pc_range, state_ff == ST_RUN, pc_ff <= PC_LAST, "step counter left the program")
   `LFPS_ASSERT_SAME(a_idle_quiet, state_ff == ST_IDLE, ctl.op == OP_NOP && !ctl.acc_upd, "datapath operation issued while idle")

endmodule

`default_nettype wire

/* hdl/lfps_datapath.sv */
// Shared multiplier, controller state registers and result register.
`default_nettype none

module lfps_datapath
   import lfps_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire lfps_ctl_type        ctl,
   input  wire lfps_cfg_type        cfg,
   input  wire logic signed [31:0]  offset_in,
   input  wire logic signed [31:0]  heading_in,
   input  wire logic                start_flag,
   input  wire logic                rsp_tready,
   output logic                     rsp_tvalid,
   output logic [30:0]              forward_speed,
   output logic signed [31:0]       turn_rate,
   output logic                     out_stall
);

   logic signed [31:0]        x_o_ff, x_h_ff;
   logic signed [31:0]        f_o_ff, f_h_ff;
   logic signed [31:0]        last_o_ff, last_h_ff;
   logic signed [31:0]        acc_o_ff, acc_h_ff;
   logic signed [31:0]        d_o_ff, d_h_ff;
   logic signed [RND_W-1:0]   slow_ff;
   logic signed [WIDE_W-1:0]  tsum_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic                      running_ff;
   logic                      rsp_valid_ff;
   logic [30:0]               speed_ff;
   logic signed [31:0]        turn_ff;

   logic signed [31:0]        e_o, e_h;
   logic signed [OPND_W-1:0]  opa, opb;
   logic signed [RND_W-1:0]   rnd;
   logic signed [RND_W-1:0]   base_ext, slow_c;
   logic signed [RND_W:0]     spd;
   logic [30:0]               speed_res;
   logic signed [31:0]        turn_res;

   // Errors are the negated filtered values.
   assign e_o = neg32(f_o_ff);
   assign e_h = neg32(f_h_ff);

   // Operand selection for the shared multiplier.
   always_comb begin
      case (ctl.mul_a)
         A_DIFF_O: opa = 33'(x_o_ff) - 33'(f_o_ff);
         A_DIFF_H: opa = 33'(x_h_ff) - 33'(f_h_ff);
         A_ABS_EO: opa = e_o[31] ? -33'(e_o) : 33'(e_o);
         A_ABS_EH: opa = e_h[31] ? -33'(e_h) : 33'(e_h);
         A_ERR_O:  opa = 33'(e_o);
         A_ERR_H:  opa = 33'(e_h);
         A_DLT_O:  opa = 33'(d_o_ff);
         A_DLT_H:  opa = 33'(d_h_ff);
         A_ACC_O:  opa = 33'(acc_o_ff);
         A_ACC_H:  opa = 33'(acc_h_ff);
         default:  opa = '0;
      endcase
      case (ctl.mul_b)
         B_COEF:  opb = COEF_OPND;
         B_SLOW:  opb = 33'(cfg.gain_slowdown);
         B_KP_O:  opb = 33'(cfg.gain_offset_p);
         B_KP_H:  opb = 33'(cfg.gain_heading_p);
         B_KD_O:  opb = 33'(cfg.gain_offset_d);
         B_KD_H:  opb = 33'(cfg.gain_heading_d);
         B_KI_O:  opb = 33'(cfg.gain_offset_i);
         B_KI_H:  opb = 33'(cfg.gain_heading_i);
         default: opb = '0;
      endcase
   end

   // The product is registered; the next step rounds and consumes it.
   always_ff @(posedge clock) begin
      prod_ff <= opa * opb;
   end

   assign rnd = rnd16(prod_ff);

   // Speed: slowdown limited to the base speed, result saturated on top.
   assign base_ext  = RND_W'($signed({1'b0, cfg.base_speed}));
   assign slow_c    = (slow_ff > base_ext) ? base_ext : slow_ff;
   assign spd       = (RND_W+1)'(base_ext) - (RND_W+1)'(slow_c);
   assign speed_res = (spd > 51'sd2147483647) ? 31'h7FFF_FFFF : spd[30:0];
   assign turn_res  = sat32(tsum_ff);

   // Sample capture and the operations of the program.
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         x_o_ff <= offset_in;
         x_h_ff <= heading_in;
      end
      case (ctl.op)
         OP_DIFF: begin
            d_o_ff <= sat32(53'(e_o) - 53'(last_o_ff));
            d_h_ff <= sat32(53'(e_h) - 53'(last_h_ff));
         end
         OP_SLOW:   slow_ff <= rnd;
         OP_TFIRST: tsum_ff <= -53'(rnd);
         OP_TSUB:   tsum_ff <= tsum_ff - 53'(rnd);
         OP_OUT: begin
            speed_ff <= running_ff ? speed_res : '0;
            turn_ff  <= running_ff ? turn_res : '0;
         end
         default: begin
         end
      endcase
   end

   // Controller state: filters, error history, accumulators, run flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         f_o_ff     <= '0;
         f_h_ff     <= '0;
         last_o_ff  <= '0;
         last_h_ff  <= '0;
         acc_o_ff   <= '0;
         acc_h_ff   <= '0;
         running_ff <= 1'b0;
      end else begin
         case (ctl.op)
            OP_FILT_O: f_o_ff <= sat32(53'(f_o_ff) + 53'(rnd));
            OP_FILT_H: f_h_ff <= sat32(53'(f_h_ff) + 53'(rnd));
            OP_DIFF: begin
               last_o_ff <= e_o;
               last_h_ff <= e_h;
            end
            default: begin
            end
         endcase
         if (ctl.acc_upd) begin
            acc_o_ff <= sat32(53'(acc_o_ff) + 53'(d_o_ff));
            acc_h_ff <= sat32(53'(acc_h_ff) + 53'(d_h_ff));
         end
         if (ctl.evt) begin
            running_ff <= start_flag;
            if (start_flag) begin
               acc_o_ff <= '0;
               acc_h_ff <= '0;
            end
         end
      end
   end

   // Result register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.op == OP_OUT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign out_stall     = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid    = rsp_valid_ff;
   assign forward_speed = speed_ff;
   assign turn_rate     = turn_ff;

endmodule

`default_nettype wire

/* hdl/line_follow_pid_steering_core.sv */
// Top level of the line-following PID steering core with configuration registers.
`default_nettype none

// Each sample request is run by a short microcode program on one shared
// 33x33 multiplier, one product per cycle: a P-law sample (tuser 0) runs
// steps 0 to 7, a PID-law sample (tuser 1) steps 0 to 2 and 8 to 16, each
// ending in a registered result; the next request is taken once the program
// ends. A start/stop event (tuser 2) is taken while idle, runs no program
// and gives no response; tuser 3 is dropped. The response register lets the
// next request run while a result waits; the program only holds at its final
// step if the previous response has not been taken. Registers must be written
// through the csr port only while the core is idle; the core does not check it.

module line_follow_pid_steering_core
   import lfps_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   // Sample and event requests.
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   // [31:0] offset_in, [63:32] heading_in, [64] start_flag, [71:65] zero
   input  wire logic [REQ_TDATA_W-1:0]  req_tdata,
   // [1:0] cmd
   input  wire logic [1:0]              req_tuser,
   // Responses.
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   // [30:0] forward_speed, [62:31] turn_rate, [63] zero
   output logic [RSP_TDATA_W-1:0]       rsp_tdata,
   // Register writes.
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_data
);

   lfps_cfg_type        cfg_ff;
   lfps_ctl_type        ctl;
   logic                out_stall;
   logic [30:0]         forward_speed;
   logic signed [31:0]  turn_rate;

   // Register file, always ready for a write.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BASE_SPEED:     cfg_ff.base_speed     <= csr_data[30:0];
            CSR_GAIN_OFFSET_P:  cfg_ff.gain_offset_p  <= csr_data;
            CSR_GAIN_HEADING_P: cfg_ff.gain_heading_p <= csr_data;
            CSR_GAIN_SLOWDOWN:  cfg_ff.gain_slowdown  <= csr_data;
            CSR_GAIN_OFFSET_I:  cfg_ff.gain_offset_i  <= csr_data;
            CSR_GAIN_HEADING_I: cfg_ff.gain_heading_i <= csr_data;
            CSR_GAIN_OFFSET_D:  cfg_ff.gain_offset_d  <= csr_data;
            CSR_GAIN_HEADING_D: cfg_ff.gain_heading_d <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Program sequencer.
   lfps_sequencer u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .out_stall  (out_stall),
      .ctl        (ctl)
   );

   // Arithmetic and state.
   lfps_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .cfg           (cfg_ff),
      .offset_in     (req_tdata[31:0]),
      .heading_in    (req_tdata[63:32]),
      .start_flag    (req_tdata[64]),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .forward_speed (forward_speed),
      .turn_rate     (turn_rate),
      .out_stall     (out_stall)
   );

   // Pack the response fields.
   assign rsp_tdata = {1'b0, turn_rate, forward_speed};

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking testbench for the line-following PID steering core.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import lfps_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD    = 600;
   localparam int MAX_REPORTS  = 40;

   // Command code that the core ignores.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Expected content of one response.
   typedef struct packed {
      logic        [30:0] forward_speed;
      logic signed [31:0] turn_rate;
   } steering_result;

   // Predicts the steering commands and checks the responses in order.
   class steering_scoreboard;
      longint base_speed;
      int gain_op, gain_hp, gain_sd, gain_oi, gain_hi, gain_od, gain_hd;
      int filt_o, filt_h, last_err_o, last_err_h, acc_o, acc_h;
      bit running;
      steering_result pending[$];
      int mismatches;

      function int clamp_i32(longint v);
         if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
         if (v < -64'sd2147483648) return 32'sh8000_0000;
         return int'(v);
      endfunction

      // Q16.16 product reduction, round half up.
      function longint round_q16(longint p);
         return (p + 64'sd32768) >>> 16;
      endfunction

      function int low_pass(int f, int x);
         return clamp_i32(longint'(f)
            + round_q16(longint'(FILTER_COEF) * (longint'(x) - longint'(f))));
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
         case (idx)
            CSR_BASE_SPEED:     base_speed = longint'(data[30:0]);
            CSR_GAIN_OFFSET_P:  gain_op = signed'(data);
            CSR_GAIN_HEADING_P: gain_hp = signed'(data);
            CSR_GAIN_SLOWDOWN:  gain_sd = signed'(data);
            CSR_GAIN_OFFSET_I:  gain_oi = signed'(data);
            CSR_GAIN_HEADING_I: gain_hi = signed'(data);
            CSR_GAIN_OFFSET_D:  gain_od = signed'(data);
            CSR_GAIN_HEADING_D: gain_hd = signed'(data);
            default: ;
         endcase
      endfunction

      // Advances the predicted state for one accepted request.
      function void note_request(logic [1:0] cmd, int off_in, int head_in, bit start);
         longint e_o, e_h, d_o, d_h, mag, slow, speed, turn, t_o, t_h;
         steering_result r;
         if (cmd == CMD_EVENT) begin
            running = start;
            if (start) begin
               acc_o = 0;
               acc_h = 0;
            end
            return;
         end
         if (cmd != CMD_P && cmd != CMD_PID) return;
         filt_o = low_pass(filt_o, off_in);
         filt_h = low_pass(filt_h, head_in);
         e_o = clamp_i32(-longint'(filt_o));
         e_h = clamp_i32(-longint'(filt_h));
         if (cmd == CMD_P) begin
            mag = (e_o < 0) ? -e_o : e_o;
            slow = round_q16(mag * gain_sd);
            turn = clamp_i32(-round_q16(e_o * gain_op) - round_q16(e_h * gain_hp));
         end else begin
            d_o = clamp_i32(e_o - last_err_o);
            d_h = clamp_i32(e_h - last_err_h);
            last_err_o = int'(e_o);
            last_err_h = int'(e_h);
            acc_o = clamp_i32(longint'(acc_o) + d_o);
            acc_h = clamp_i32(longint'(acc_h) + d_h);
            mag = (e_h < 0) ? -e_h : e_h;
            slow = round_q16(mag * gain_sd);
            t_o = round_q16(e_o * gain_op) + round_q16(d_o * gain_od)
                + round_q16(longint'(acc_o) * gain_oi);
            t_h = round_q16(e_h * gain_hp) + round_q16(d_h * gain_hd)
                + round_q16(longint'(acc_h) * gain_hi);
            turn = clamp_i32(-t_o - t_h);
         end
         // The slowdown never exceeds the base speed; a negative one raises it.
         if (slow > base_speed) slow = base_speed;
         speed = base_speed - slow;
         if (speed < 0) speed = 0;
         if (speed > 64'sd2147483647) speed = 64'sd2147483647;
         if (!running) begin
            speed = 0;
            turn = 0;
         end
         r.forward_speed = speed[30:0];
         r.turn_rate = turn[31:0];
         pending.push_back(r);
      endfunction

      function void check_response(logic [RSP_TDATA_W-1:0] tdata);
         steering_result want;
         logic [30:0] got_speed;
         logic signed [31:0] got_turn;
         got_speed = tdata[30:0];
         got_turn = signed'(tdata[62:31]);
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $error("unexpected response: forward_speed %0d, turn_rate %0d",
                      got_speed, got_turn);
            return;
         end
         want = pending.pop_front();
         if (got_speed !== want.forward_speed) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $error("forward_speed mismatch: expected %0d, got %0d",
                      want.forward_speed, got_speed);
         end
         if (got_turn !== want.turn_rate) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $error("turn_rate mismatch: expected %0d, got %0d",
                      want.turn_rate, got_turn);
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [1:0]             req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   steering_scoreboard sb = new();
   bit hold_rsp_req = 1'b0;
   int burst_left = 0;

   line_follow_pid_steering_core DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   // Offers one request and waits until the core takes it.
   task automatic send_request(logic [1:0] cmd, logic [31:0] off_in,
                               logic [31:0] head_in, bit start);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {7'b0, start, head_in, off_in};
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, signed'(off_in), signed'(head_in), start);
   endtask

   // Bursts of random length separated by random gaps.
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Stops offering and waits for every outstanding response.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_register(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_config(lfps_cfg_type c);
      write_csr(CSR_BASE_SPEED, {1'b0, c.base_speed});
      write_csr(CSR_GAIN_OFFSET_P, c.gain_offset_p);
      write_csr(CSR_GAIN_HEADING_P, c.gain_heading_p);
      write_csr(CSR_GAIN_SLOWDOWN, c.gain_slowdown);
      write_csr(CSR_GAIN_OFFSET_I, c.gain_offset_i);
      write_csr(CSR_GAIN_HEADING_I, c.gain_heading_i);
      write_csr(CSR_GAIN_OFFSET_D, c.gain_offset_d);
      write_csr(CSR_GAIN_HEADING_D, c.gain_heading_d);
   endtask

   // Measurement values: mostly moderate, some full range and extremes.
   function automatic logic [31:0] pick_measure();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
         4, 5:       return $urandom_range(0, 32'h1FF_FFFF) - 32'h100_0000;
         6, 7:       return $urandom;
         default: begin
            case ($urandom_range(0, 3))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0;
               default: return 32'hFFFF_FFFF;
            endcase
         end
      endcase
   endfunction

   function automatic logic [31:0] pick_gain();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return $urandom_range(0, 32'h4_0000) - 32'h2_0000;
         5, 6:          return $urandom_range(0, 32'h2000) - 32'h1000;
         7:             return $urandom;
         default:       return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      endcase
   endfunction

   function automatic logic [30:0] pick_base();
      case ($urandom_range(0, 5))
         0:       return 31'h0;
         1:       return 31'h7FFF_FFFF;
         2:       return $urandom;
         default: return $urandom_range(32'h1_0000, 32'h10_0000);
      endcase
   endfunction

   function automatic lfps_cfg_type random_config();
      lfps_cfg_type c;
      c.base_speed = pick_base();
      c.gain_offset_p = pick_gain();
      c.gain_heading_p = pick_gain();
      c.gain_slowdown = pick_gain();
      c.gain_offset_i = pick_gain();
      c.gain_heading_i = pick_gain();
      c.gain_offset_d = pick_gain();
      c.gain_heading_d = pick_gain();
      return c;
   endfunction

   // One phase of random traffic: a start event, then mostly samples with
   // occasional stops, restarts and unused commands.
   task automatic random_phase(int n_items, int phase);
      int pick;
      send_request(CMD_EVENT, $urandom, $urandom, 1'b1);
      for (int i = 0; i < n_items; i++) begin
         if (phase == 3 && i == n_items / 4) hold_rsp_req = 1'b1;
         if (phase == 5 && i == n_items / 2) drain();
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            send_request(CMD_EVENT, $urandom, $urandom, 1'b0);
         end else if (pick < 6) begin
            send_request(CMD_EVENT, $urandom, $urandom, 1'b1);
         end else if (pick < 8) begin
            send_request(CMD_UNUSED, $urandom, $urandom, $urandom_range(0, 1));
         end else begin
            send_request(($urandom_range(0, 99) < 55) ? CMD_PID : CMD_P,
                         pick_measure(), pick_measure(), $urandom_range(0, 1));
         end
         pace();
      end
   endtask

   // Response side: changing stall patterns plus one long hold-off.
   initial begin : response_side
      int mode;
      int mode_left;
      int hold_left;
      int tick;
      mode = 0;
      mode_left = 0;
      hold_left = 0;
      tick = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         @(negedge clock);
         tick++;
         if (hold_rsp_req) begin
            hold_rsp_req = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 9) < 7);
               2: rsp_tready <= ($urandom_range(0, 9) < 3);
               default: rsp_tready <= (tick % 4 == 0);
            endcase
         end
      end
   end

   // Watchdog on the whole run.
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL line_follow_pid_steering_core");
      $finish;
   end

   // Main stimulus.
   initial begin : stimulus
      lfps_cfg_type cfg;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = CMD_P;
      csr_valid = 1'b0;
      csr_index = CSR_BASE_SPEED;
      csr_data = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part with moderate gains, one of them negative.
      cfg = '{31'h0003_0000, 32'h0001_8000, 32'h0000_C000, 32'h0000_4000,
              32'h0000_2000, 32'hFFFF_E000, 32'h0000_6000, 32'h0000_1000};
      load_config(cfg);
      // Samples while stopped still move the filter and the PID history.
      send_request(CMD_P, 32'h0002_0000, 32'hFFFF_0000, 1'b0);
      send_request(CMD_PID, 32'h0001_0000, 32'h0000_8000, 1'b1);
      send_request(CMD_EVENT, 32'h0, 32'h0, 1'b1);
      send_request(CMD_P, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      send_request(CMD_P, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
      send_request(CMD_PID, 32'h0, 32'h0, 1'b0);
      send_request(CMD_PID, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_request(CMD_PID, 32'h8000_0000, 32'h8000_0000, 1'b1);
      // The unused command must leave everything untouched.
      send_request(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      send_request(CMD_P, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
      send_request(CMD_EVENT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_request(CMD_PID, 32'h0004_0000, 32'hFFFC_0000, 1'b0);
      send_request(CMD_P, 32'h0004_0000, 32'hFFFC_0000, 1'b1);
      // Restarting clears the accumulators but keeps the last errors.
      send_request(CMD_EVENT, 32'h0, 32'h0, 1'b1);
      send_request(CMD_EVENT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      send_request(CMD_PID, 32'h0001_0000, 32'h0, 1'b0);
      send_request(CMD_PID, 32'h0001_0000, 32'h0, 1'b0);
      send_request(CMD_P, 32'h0, 32'h0, 1'b0);
      // Drive the filters toward both rails.
      repeat (3) send_request(CMD_PID, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      repeat (3) send_request(CMD_P, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      // Random phases, each under its own register setting.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: cfg = '{31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
            1: cfg = '{31'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
            2: begin
               // Negative slowdown against a large base speed.
               cfg = random_config();
               cfg.base_speed = 31'h7FFF_FFF0;
               cfg.gain_slowdown = 32'hFFF0_0000;
            end
            default: cfg = random_config();
         endcase
         load_config(cfg);
         random_phase(105, phase);
         drain();
         repeat (SETTLE_CYCLES) @(posedge clock);
      end

      if (sb.mismatches == 0) begin
         $display("PASS line_follow_pid_steering_core");
      end else begin
         $display("FAIL line_follow_pid_steering_core");
      end
      $finish;
   end

endmodule

`default_nettype wire
